// ===== rtl/cfs_pkg.sv =====
// Shared types and constants for the cube face selection pipeline.
// No dependencies; every rtl module imports this package.
package cfs_pkg;

    // Field widths
    localparam int CW        = 24;          // direction component width
    localparam int NFB       = 14;          // fraction bits of the face coordinates
    localparam int NDC_W     = 16;          // width of a face coordinate
    localparam int MIN_MAG_W = 23;          // width of the magnitude threshold
    localparam int MAG_W     = CW;          // holds a magnitude up to 2^(CW-1)

    localparam logic [MIN_MAG_W-1:0] MIN_MAG_RESET = MIN_MAG_W'(4);

    // Divider: NFB quotient bits below the integer bit, split evenly over stages.
    // NFB must be a multiple of DIV_BITS_PER_STAGE.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = NFB / DIV_BITS_PER_STAGE;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } cfs_face_t;

    // Input item
    typedef struct packed {
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
    } cfs_dir_t;

    // Result item
    typedef struct packed {
        logic                    valid_res;
        cfs_face_t               face;
        logic signed [NDC_W-1:0] ndc_x;
        logic signed [NDC_W-1:0] ndc_y;
    } cfs_res_t;

    // Item state carried down the divider pipeline
    typedef struct packed {
        logic             vld;      // an item occupies this stage
        logic             ok;       // major magnitude above threshold
        cfs_face_t        face;
        logic [MAG_W-1:0] m;        // divisor: major magnitude
        logic [MAG_W-1:0] rem_x;    // partial remainders
        logic [MAG_W-1:0] rem_y;
        logic [NFB-1:0]   q_x;      // fraction quotient bits so far
        logic [NFB-1:0]   q_y;
        logic             eq_x;     // numerator equals divisor: quotient is exactly one
        logic             eq_y;
        logic             neg_x;    // negate the final coordinate
        logic             neg_y;
    } cfs_div_t;

endpackage

// ===== rtl/cube_face_select_project.sv =====
// Top level of the cube face selection pipeline.
// Depends on cfs_pkg, cfs_face_sel, cfs_div_stage, cfs_out_stage.
//
// Usage:
//   Input: drive dir and raise start; an item is taken at each rising edge
//   with start high and busy low. busy stays low, so one direction can be
//   taken every cycle.
//   Output: done is high for one cycle with result (valid_res, face, ndc_x,
//   ndc_y). The receiver must take it in that cycle; there is no stall.
//   Stages: one for face pick, one per two quotient bits of the restoring
//   divider, one for the sign and result register. Throughput is one item
//   per cycle. Results leave in the order their items arrived.
//   Config: min_magnitude is written through cfg_valid/cfg_ready/cfg_data,
//   always ready; write it only while no item is in flight.
//   Reset: rst_n clears all stage valid bits and the done strobe, and sets
//   min_magnitude to 4. No clearing pass is needed.
module cube_face_select_project (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  cfs_pkg::cfs_dir_t                 dir,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfs_pkg::MIN_MAG_W-1:0]     cfg_data,
    output logic                              done,
    output cfs_pkg::cfs_res_t                 result
);
    import cfs_pkg::*;

    logic [MIN_MAG_W-1:0] min_mag_reg;
    cfs_div_t             pipe [DIV_STAGES+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_mag_reg <= MIN_MAG_RESET;
        else if (cfg_valid && cfg_ready)
            min_mag_reg <= cfg_data;
    end

    // Face pick
    cfs_face_sel u_face_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (start && !busy),
        .dir        (dir),
        .min_mag    (min_mag_reg),
        .stage_out  (pipe[0])
    );

    // Divider pipeline
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        cfs_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (pipe[s]),
            .stage_out (pipe[s+1])
        );
    end

    // Sign and result register
    cfs_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (pipe[DIV_STAGES]),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== rtl/cfs_face_sel.sv =====
// First pipeline stage: major axis and face pick, numerator select, threshold check.
// Depends on cfs_pkg.
module cfs_face_sel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  cfs_pkg::cfs_dir_t                 dir,
    input  logic [cfs_pkg::MIN_MAG_W-1:0]     min_mag,
    output cfs_pkg::cfs_div_t                 stage_out
);
    import cfs_pkg::*;

    logic [MAG_W-1:0] mag_x, mag_y, mag_z;
    logic [MAG_W-1:0] bits_x, bits_y, bits_z;
    logic             sgn_x, sgn_y, sgn_z;
    logic             x_over_y, z_wins;
    logic [MAG_W-1:0] m_xy, m_max;
    cfs_face_t        face;
    logic [MAG_W-1:0] num_x, num_y;
    logic             neg_x, neg_y;
    cfs_div_t         stage_next, stage_reg;

    // Component magnitudes
    assign bits_x = dir.dir_x;
    assign bits_y = dir.dir_y;
    assign bits_z = dir.dir_z;
    assign sgn_x  = bits_x[CW-1];
    assign sgn_y  = bits_y[CW-1];
    assign sgn_z  = bits_z[CW-1];
    assign mag_x  = sgn_x ? (~bits_x + 1'b1) : bits_x;
    assign mag_y  = sgn_y ? (~bits_y + 1'b1) : bits_y;
    assign mag_z  = sgn_z ? (~bits_z + 1'b1) : bits_z;

    // Major axis; ties go to the lower axis
    assign x_over_y = (mag_x >= mag_y);
    assign m_xy     = x_over_y ? mag_x : mag_y;
    assign z_wins   = (mag_z > m_xy);
    assign m_max    = z_wins ? mag_z : m_xy;

    always_comb
    begin
        if (z_wins)
            face = sgn_z ? FACE_NEG_Z : FACE_POS_Z;
        else if (x_over_y)
            face = sgn_x ? FACE_NEG_X : FACE_POS_X;
        else
            face = sgn_y ? FACE_NEG_Y : FACE_POS_Y;
    end

    // Numerators per face; y sign folds in the final vertical flip
    always_comb
    begin
        case (face)
            FACE_POS_X:
            begin
                num_x = mag_z; neg_x = sgn_z;  num_y = mag_y; neg_y = ~sgn_y;
            end
            FACE_NEG_X:
            begin
                num_x = mag_z; neg_x = ~sgn_z; num_y = mag_y; neg_y = ~sgn_y;
            end
            FACE_POS_Y:
            begin
                num_x = mag_x; neg_x = sgn_x;  num_y = mag_z; neg_y = ~sgn_z;
            end
            FACE_NEG_Y:
            begin
                num_x = mag_x; neg_x = ~sgn_x; num_y = mag_z; neg_y = ~sgn_z;
            end
            FACE_POS_Z:
            begin
                num_x = mag_x; neg_x = ~sgn_x; num_y = mag_y; neg_y = ~sgn_y;
            end
            default:
            begin
                num_x = mag_x; neg_x = sgn_x;  num_y = mag_y; neg_y = ~sgn_y;
            end
        endcase
    end

    // Stage contents
    always_comb
    begin
        stage_next.vld   = item_valid;
        stage_next.ok    = (m_max > MAG_W'(min_mag));
        stage_next.face  = face;
        stage_next.m     = m_max;
        stage_next.rem_x = num_x;
        stage_next.rem_y = num_y;
        stage_next.q_x   = '0;
        stage_next.q_y   = '0;
        stage_next.eq_x  = (num_x == m_max);
        stage_next.eq_y  = (num_y == m_max);
        stage_next.neg_x = neg_x;
        stage_next.neg_y = neg_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/cfs_div_stage.sv =====
// One divider stage: DIV_BITS_PER_STAGE restoring steps on both coordinates.
// Depends on cfs_pkg.
module cfs_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  cfs_pkg::cfs_div_t stage_in,
    output cfs_pkg::cfs_div_t stage_out
);
    import cfs_pkg::*;

    cfs_div_t stage_next, stage_reg;

    // Shift, compare against the divisor, subtract when it fits
    always_comb
    begin
        logic [MAG_W:0] tx, ty, dv;
        stage_next = stage_in;
        dv = {1'b0, stage_in.m};
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++)
        begin
            tx = {stage_next.rem_x, 1'b0};
            ty = {stage_next.rem_y, 1'b0};
            if (tx >= dv)
            begin
                stage_next.rem_x = MAG_W'(tx - dv);
                stage_next.q_x   = {stage_next.q_x[NFB-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem_x = tx[MAG_W-1:0];
                stage_next.q_x   = {stage_next.q_x[NFB-2:0], 1'b0};
            end
            if (ty >= dv)
            begin
                stage_next.rem_y = MAG_W'(ty - dv);
                stage_next.q_y   = {stage_next.q_y[NFB-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem_y = ty[MAG_W-1:0];
                stage_next.q_y   = {stage_next.q_y[NFB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/cfs_out_stage.sv =====
// Last stage: quotient assembly, sign, zeroing of invalid items, result register.
// Depends on cfs_pkg.
module cfs_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  cfs_pkg::cfs_div_t stage_in,
    output logic              done,
    output cfs_pkg::cfs_res_t result
);
    import cfs_pkg::*;

    localparam logic [NDC_W-1:0] ONE = NDC_W'(1) << NFB;

    logic [NDC_W-1:0] mag_x, mag_y;
    cfs_res_t         result_next, result_reg;
    logic             done_reg;

    // Quotient is exactly one when numerator equals divisor
    assign mag_x = stage_in.eq_x ? ONE : NDC_W'(stage_in.q_x);
    assign mag_y = stage_in.eq_y ? ONE : NDC_W'(stage_in.q_y);

    always_comb
    begin
        result_next = '0;
        if (stage_in.ok)
        begin
            result_next.valid_res = 1'b1;
            result_next.face      = stage_in.face;
            result_next.ndc_x     = stage_in.neg_x ? (~mag_x + 1'b1) : mag_x;
            result_next.ndc_y     = stage_in.neg_y ? (~mag_y + 1'b1) : mag_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg   <= stage_in.vld;
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== test/cube_face_select_project_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cube_face_select_project: directed table, then random directions.
// Depends on cfs_pkg and the cube_face_select_project rtl.
module cube_face_select_project_tb;
    import cfs_pkg::*;

    localparam int LATENCY = DIV_STAGES + 2;
    localparam int NUM_CASES = 23;
    localparam int NUM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 185;

    localparam logic signed [CW-1:0] C_ONE  = 24'sh400000;
    localparam logic signed [CW-1:0] C_MAXP = 24'sh7fffff;
    localparam logic signed [CW-1:0] C_MINN = 24'sh800000;
    localparam logic signed [NDC_W-1:0] NDC_ONE = 16'sd16384;
    localparam cfs_res_t NO_RESULT = '0;

    // One directed row: direction, and a hand-written expectation if fixed_exp is set
    typedef struct {
        cfs_dir_t d;
        bit       fixed_exp;
        cfs_res_t res;
    } dir_case_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cfs_dir_t         dir = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [MIN_MAG_W-1:0] cfg_data = '0;
    logic             done;
    cfs_res_t         result;

    cfs_res_t         pending_faces [$];
    logic [MIN_MAG_W-1:0] min_mag_model = MIN_MAG_RESET;
    int               mismatches = 0;

    // Directed rows, run with the reset threshold of 4
    dir_case_t dir_cases [NUM_CASES] = '{
        '{'{24'sd0, 24'sd0, 24'sd0}, 1'b1, NO_RESULT},
        '{'{24'sd4, 24'sd0, 24'sd0}, 1'b1, NO_RESULT},
        '{'{-24'sd4, 24'sd0, 24'sd0}, 1'b1, NO_RESULT},
        '{'{24'sd5, 24'sd0, 24'sd0}, 1'b1, '{1'b1, FACE_POS_X, 16'sd0, 16'sd0}},
        '{'{C_ONE, 24'sd0, 24'sd0}, 1'b1, '{1'b1, FACE_POS_X, 16'sd0, 16'sd0}},
        '{'{-C_ONE, 24'sd0, 24'sd0}, 1'b1, '{1'b1, FACE_NEG_X, 16'sd0, 16'sd0}},
        '{'{24'sd0, C_ONE, 24'sd0}, 1'b1, '{1'b1, FACE_POS_Y, 16'sd0, 16'sd0}},
        '{'{24'sd0, -C_ONE, 24'sd0}, 1'b1, '{1'b1, FACE_NEG_Y, 16'sd0, 16'sd0}},
        '{'{24'sd0, 24'sd0, C_ONE}, 1'b1, '{1'b1, FACE_POS_Z, 16'sd0, 16'sd0}},
        '{'{24'sd0, 24'sd0, -C_ONE}, 1'b1, '{1'b1, FACE_NEG_Z, 16'sd0, 16'sd0}},
        '{'{C_MINN, 24'sd0, 24'sd0}, 1'b1, '{1'b1, FACE_NEG_X, 16'sd0, 16'sd0}},
        '{'{C_MAXP, 24'sd0, 24'sd0}, 1'b1, '{1'b1, FACE_POS_X, 16'sd0, 16'sd0}},
        '{'{C_ONE, C_ONE, C_ONE}, 1'b1, '{1'b1, FACE_POS_X, NDC_ONE, -NDC_ONE}},
        '{'{-C_ONE, -C_ONE, -C_ONE}, 1'b1, '{1'b1, FACE_NEG_X, NDC_ONE, NDC_ONE}},
        '{'{C_MINN, C_MINN, C_MINN}, 1'b1, '{1'b1, FACE_NEG_X, NDC_ONE, NDC_ONE}},
        '{'{24'sd0, C_ONE, -C_ONE}, 1'b1, '{1'b1, FACE_POS_Y, 16'sd0, NDC_ONE}},
        '{'{C_MAXP, C_MINN, 24'sd0}, 1'b0, NO_RESULT},
        '{'{24'sd123456, -24'sd2345678, 24'sd3000000}, 1'b0, NO_RESULT},
        '{'{-24'sd3000000, 24'sd1000, 24'sd2999999}, 1'b0, NO_RESULT},
        '{'{24'sd1, -24'sd1, 24'sd0}, 1'b0, NO_RESULT},
        '{'{C_MAXP, C_MAXP - 24'sd1, 24'sd1 - C_MAXP}, 1'b0, NO_RESULT},
        '{'{-24'sd5000, 24'sd70000, -24'sd70001}, 1'b0, NO_RESULT},
        '{'{24'sd2500000, -24'sd2600000, 24'sd100}, 1'b0, NO_RESULT}
    };

    cube_face_select_project dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dir       (dir),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Signed minor / major in Q1.NFB, truncated toward zero
    function automatic longint face_ratio(longint n, longint m);
        longint q;
        q = ((n < 0 ? -n : n) << NFB) / m;
        return (n < 0) ? -q : q;
    endfunction

    // Expected face and coordinates of one direction at a given threshold
    function automatic cfs_res_t predict_face(cfs_dir_t d, logic [MIN_MAG_W-1:0] thr);
        longint    c [3];
        longint    top_dot;
        longint    dp;
        longint    nx;
        longint    ny;
        longint    qx;
        longint    qy;
        longint    one;
        cfs_face_t best;
        cfs_res_t  r;
        c[0] = longint'($signed(d.dir_x));
        c[1] = longint'($signed(d.dir_y));
        c[2] = longint'($signed(d.dir_z));
        one = longint'(1) << NFB;
        r = NO_RESULT;
        top_dot = -1;
        best = FACE_POS_X;
        // scan faces in order; only a strictly larger dot product wins
        for (int f = 0; f < 6; f++)
        begin
            dp = (f % 2 == 1) ? -c[f / 2] : c[f / 2];
            if (dp > top_dot)
            begin
                top_dot = dp;
                best = cfs_face_t'(f);
            end
        end
        if (top_dot <= 0 || top_dot <= longint'(thr))
            return r;
        case (best)
            FACE_POS_X: begin nx =  c[2]; ny = c[1]; end
            FACE_NEG_X: begin nx = -c[2]; ny = c[1]; end
            FACE_POS_Y: begin nx =  c[0]; ny = c[2]; end
            FACE_NEG_Y: begin nx = -c[0]; ny = c[2]; end
            FACE_POS_Z: begin nx = -c[0]; ny = c[1]; end
            default:    begin nx =  c[0]; ny = c[1]; end
        endcase
        qx = face_ratio(nx, top_dot);
        qy = -face_ratio(ny, top_dot);
        if (qx < -one || qx > one || qy < -one || qy > one)
            return r;
        r.valid_res = 1'b1;
        r.face = best;
        r.ndc_x = qx[NDC_W-1:0];
        r.ndc_y = qy[NDC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Drive one direction and hold it until taken; log its expected result
    task automatic send_dir(cfs_dir_t d, bit fixed_exp, cfs_res_t fixed_res);
        start <= 1'b1;
        dir <= d;
        do @(posedge clk); while (busy);
        pending_faces.push_back(fixed_exp ? fixed_res : predict_face(d, min_mag_model));
    endtask

    // Threshold write; only called with no item in flight
    task automatic write_min_mag(logic [MIN_MAG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_mag_model = value;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        cfs_res_t want;
        if (rst_n && done)
        begin
            if (pending_faces.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
            end
            else
            begin
                want = pending_faces.pop_front();
                if (result.valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res got %0d expected %0d",
                                              result.valid_res, want.valid_res));
                if (result.face !== want.face)
                    report_mismatch($sformatf("face got %0d expected %0d",
                                              result.face, want.face));
                if (result.ndc_x !== want.ndc_x)
                    report_mismatch($sformatf("ndc_x got %0d expected %0d",
                                              $signed(result.ndc_x), $signed(want.ndc_x)));
                if (result.ndc_y !== want.ndc_y)
                    report_mismatch($sformatf("ndc_y got %0d expected %0d",
                                              $signed(result.ndc_y), $signed(want.ndc_y)));
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [MIN_MAG_W-1:0] phase_thr [NUM_PHASES];
        longint   comp [3];
        longint   span;
        longint   big;
        logic [31:0] rbits;
        logic [3*32-1:0] wide;
        cfs_dir_t rdir;
        int       idle_pct;
        int       mode;
        int       i;
        int       j;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset threshold
        foreach (dir_cases[k])
        begin
            send_dir(dir_cases[k].d, dir_cases[k].fixed_exp, dir_cases[k].res);
            if ($urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end

        phase_thr[0] = MIN_MAG_RESET;
        phase_thr[1] = '0;
        phase_thr[2] = {MIN_MAG_W{1'b1}};
        phase_thr[3] = MIN_MAG_W'($urandom_range(0, 8388607));
        phase_thr[4] = MIN_MAG_W'($urandom_range(1, 64));
        phase_thr[5] = 23'd4194304;
        phase_thr[6] = MIN_MAG_RESET;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // drain the pipeline before touching the threshold
            start <= 1'b0;
            while (pending_faces.size() != 0) @(posedge clk);
            if (p != 0)
                write_min_mag(phase_thr[p]);
            idle_pct = (p == NUM_PHASES - 1) ? 0 : $urandom_range(0, 50);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                mode = $urandom_range(0, 9);
                for (int a = 0; a < 3; a++)
                begin
                    rbits = $urandom;
                    comp[a] = longint'($signed(rbits[CW-1:0]));
                end
                case (mode)
                    // magnitudes around the threshold
                    4:
                    begin
                        span = longint'(min_mag_model) + 8;
                        for (int a = 0; a < 3; a++)
                        begin
                            comp[a] = longint'($urandom_range(0,
                                          int'(span > 8388608 ? 8388608 : span)));
                            if ($urandom_range(0, 1) == 1)
                                comp[a] = -comp[a];
                        end
                    end
                    // two axes tied in magnitude
                    5:
                    begin
                        i = $urandom_range(0, 2);
                        j = (i + $urandom_range(1, 2)) % 3;
                        comp[j] = ($urandom_range(0, 1) == 1) ? -comp[i] : comp[i];
                        if ($urandom_range(0, 1) == 1)
                            comp[3 - i - j] = comp[i];
                    end
                    // extremes and threshold edges
                    6:
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            case ($urandom_range(0, 6))
                                0: comp[a] = -8388608;
                                1: comp[a] = 8388607;
                                2: comp[a] = 0;
                                3: comp[a] = 1;
                                4: comp[a] = -1;
                                5: comp[a] = longint'(min_mag_model);
                                default: comp[a] = longint'(min_mag_model) + 1;
                            endcase
                            if ($urandom_range(0, 1) == 1)
                                comp[a] = -comp[a];
                        end
                    end
                    // one axis that no other axis exceeds in magnitude
                    7, 8:
                    begin
                        i = $urandom_range(0, 2);
                        big = longint'($urandom_range(1, 8388608));
                        for (int a = 0; a < 3; a++)
                        begin
                            if (a != i)
                            begin
                                comp[a] = longint'($urandom_range(0, int'(big)));
                                if ($urandom_range(0, 1) == 1)
                                    comp[a] = -comp[a];
                            end
                        end
                        comp[i] = ($urandom_range(0, 1) == 1) ? -big : big;
                    end
                    default:
                    begin
                        wide = {$urandom, $urandom, $urandom};
                        comp[0] = longint'($signed(wide[CW-1:0]));
                        comp[1] = longint'($signed(wide[2*CW-1:CW]));
                        comp[2] = longint'($signed(wide[3*CW-1:2*CW]));
                    end
                endcase
                for (int a = 0; a < 3; a++)
                begin
                    if (comp[a] > 8388607)
                        comp[a] = 8388607;
                    if (comp[a] < -8388608)
                        comp[a] = -8388608;
                end
                rdir.dir_x = comp[0][CW-1:0];
                rdir.dir_y = comp[1][CW-1:0];
                rdir.dir_z = comp[2][CW-1:0];
                send_dir(rdir, 1'b0, NO_RESULT);
                if ($urandom_range(0, 99) < idle_pct)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge clk);
                end
            end
        end

        // drain, then watch for stray strobes
        start <= 1'b0;
        while (pending_faces.size() != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
